/* rtl/core/clts_pkg.sv */
// package for the bcd clock time setter
// event codes, setting steps, clock register addresses and shared types
// no dependencies
package clts_pkg;

    typedef logic [1:0] step_t;
    typedef logic [1:0] mode_t;
    typedef logic [1:0] addr_t;

    localparam step_t STEP_HOURS   = 2'd0;
    localparam step_t STEP_MINUTES = 2'd1;
    localparam step_t STEP_SECONDS = 2'd2;
    localparam step_t STEP_IDLE    = 2'd3;

    localparam mode_t MODE_TICK = 2'd0;
    localparam mode_t MODE_SET  = 2'd1;
    localparam mode_t MODE_UP   = 2'd2;
    localparam mode_t MODE_DOWN = 2'd3;

    localparam addr_t ADDR_SECONDS = 2'd0;
    localparam addr_t ADDR_MINUTES = 2'd1;
    localparam addr_t ADDR_HOURS   = 2'd2;

    typedef struct packed {
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
    } time_t;

    typedef struct packed {
        logic       ticking;
        logic [7:0] write_data;
        addr_t      write_address;
        logic       write_valid;
        logic [7:0] shown_seconds;
        logic [7:0] shown_minutes;
        logic [7:0] shown_hours;
        step_t      setting_field;
    } result_t;

endpackage

/* rtl/core/bcd_clock_time_setter.sv */
// bcd clock time setter top level: input register, update logic, result register
// an accepted input passes the input register, the update logic and the result register, one pass
// throughput: one item per cycle while the output is not stalled, the update logic settles within the cycle
// the result register is freed in the same cycle it is taken, so no bubbles under load
// reset: setting step goes to not setting, time bytes to zero, both stages empty
// depends on clts_pkg, clts_update
module bcd_clock_time_setter
    import clts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // rtc_seconds, rtc_minutes, rtc_hours
    input  logic [1:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // setting_field, shown_hours, shown_minutes, shown_seconds, write_valid,
    // write_address, write_data, ticking, zero pad
    output logic [39:0] m_axis_tdata
);

    logic       in_valid_reg;
    mode_t      in_mode_reg;
    logic [7:0] in_sec_reg;
    logic [7:0] in_min_reg;
    logic [7:0] in_hrs_reg;
    logic       out_valid_reg;
    result_t    out_data_reg;
    step_t      step_reg;
    time_t      time_reg;

    step_t      step_next;
    time_t      time_next;
    result_t    result_next;
    logic       out_free;
    logic       advance;
    logic       in_take;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    clts_update u_update (
        .step        (step_reg),
        .cur_time    (time_reg),
        .mode        (in_mode_reg),
        .rtc_seconds (in_sec_reg),
        .rtc_minutes (in_min_reg),
        .rtc_hours   (in_hrs_reg),
        .step_next   (step_next),
        .time_next   (time_next),
        .result      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= STEP_IDLE;
            time_reg      <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                step_reg      <= step_next;
                time_reg      <= time_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_mode_reg <= s_axis_tuser;
            in_sec_reg  <= s_axis_tdata[7:0];
            in_min_reg  <= s_axis_tdata[15:8];
            in_hrs_reg  <= s_axis_tdata[23:16];
        end
        if (advance)
        begin
            out_data_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_data_reg};

endmodule

/* rtl/core/clts_adjust.sv */
// nibble-wise bcd up/down step of one time byte
// hours wrap within 0..23, minutes and seconds within 0..59
// depends on clts_pkg
module clts_adjust
    import clts_pkg::*;
(
    input  logic [7:0] value,
    input  logic       hours,
    input  logic       down,
    output logic [7:0] result
);

    logic [4:0] up_lo;
    logic [3:0] up_hi;
    logic [3:0] dn_lo;
    logic [3:0] dn_hi;
    logic [7:0] up_val;
    logic [7:0] dn_val;

    always_comb
    begin
        up_lo = {1'b0, value[3:0]} + 5'd1;
        up_hi = value[7:4];
        if (hours)
        begin
            if (up_hi < 4'd2 && up_lo == 5'd10)
            begin
                up_lo = 5'd0;
                up_hi = up_hi + 4'd1;
            end
            if (up_hi == 4'd2 && up_lo == 5'd4)
            begin
                up_lo = 5'd0;
                up_hi = 4'd0;
            end
        end
        else if (up_lo == 5'd10)
        begin
            up_lo = 5'd0;
            up_hi = up_hi + 4'd1;
            if (up_hi == 4'd6)
            begin
                up_hi = 4'd0;
            end
        end
        up_val = {up_hi, 4'b0000} | {3'b000, up_lo};
    end

    always_comb
    begin
        dn_lo = value[3:0] - 4'd1;
        dn_hi = value[7:4];
        if (value[3:0] == 4'd0)
        begin
            if (hours && dn_hi == 4'd0)
            begin
                dn_lo = 4'd3;
                dn_hi = 4'd2;
            end
            else if (!hours && dn_hi == 4'd0)
            begin
                dn_lo = 4'd9;
                dn_hi = 4'd5;
            end
            else
            begin
                dn_lo = 4'd9;
                dn_hi = dn_hi - 4'd1;
            end
        end
        dn_val = {dn_hi, dn_lo};
    end

    assign result = down ? dn_val : up_val;

endmodule

/* rtl/core/clts_update.sv */
// next-state and result logic for one event item
// tick load, set sequencing with register write, up/down field adjust
// depends on clts_pkg and clts_adjust
module clts_update
    import clts_pkg::*;
(
    input  step_t      step,
    input  time_t      cur_time,
    input  mode_t      mode,
    input  logic [7:0] rtc_seconds,
    input  logic [7:0] rtc_minutes,
    input  logic [7:0] rtc_hours,
    output step_t      step_next,
    output time_t      time_next,
    output result_t    result
);

    logic [7:0] sel_byte;
    logic [7:0] adj_byte;
    addr_t      sel_addr;
    logic       wvalid;

    always_comb
    begin
        unique case (step)
            STEP_HOURS:
            begin
                sel_addr = ADDR_HOURS;
                sel_byte = cur_time.hours;
            end
            STEP_MINUTES:
            begin
                sel_addr = ADDR_MINUTES;
                sel_byte = cur_time.minutes;
            end
            default:
            begin
                sel_addr = ADDR_SECONDS;
                sel_byte = cur_time.seconds;
            end
        endcase
    end

    clts_adjust u_adjust (
        .value  (sel_byte),
        .hours  (step == STEP_HOURS),
        .down   (mode == MODE_DOWN),
        .result (adj_byte)
    );

    always_comb
    begin
        step_next = step;
        time_next = cur_time;
        wvalid    = 1'b0;
        unique case (mode)
            MODE_TICK:
            begin
                if (step == STEP_IDLE)
                begin
                    time_next.seconds = rtc_seconds;
                    time_next.minutes = rtc_minutes;
                    time_next.hours   = rtc_hours;
                end
            end
            MODE_SET:
            begin
                if (step == STEP_IDLE)
                begin
                    step_next = STEP_HOURS;
                end
                else
                begin
                    wvalid    = 1'b1;
                    step_next = step + 2'd1;
                end
            end
            default:
            begin
                if (step != STEP_IDLE)
                begin
                    unique case (step)
                        STEP_HOURS:   time_next.hours   = adj_byte;
                        STEP_MINUTES: time_next.minutes = adj_byte;
                        default:      time_next.seconds = adj_byte;
                    endcase
                end
            end
        endcase
    end

    always_comb
    begin
        result.setting_field = step_next;
        result.shown_hours   = time_next.hours;
        result.shown_minutes = time_next.minutes;
        result.shown_seconds = time_next.seconds;
        result.write_valid   = wvalid;
        result.write_address = wvalid ? sel_addr : ADDR_SECONDS;
        result.write_data    = wvalid ? sel_byte : 8'd0;
        result.ticking       = (step_next == STEP_IDLE);
    end

endmodule
